[src/modbus_response_unpacker_macros.svh]
// Assertion macros shared by the modbus response unpacker modules.
// Each macro expands to one labeled concurrent assertion with an active-low reset.
`ifndef MODBUS_RESPONSE_UNPACKER_MACROS_SVH
`define MODBUS_RESPONSE_UNPACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MBRU_ASSERT_SAME(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MBRU_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mbru_pkg.sv]
// Package for the modbus response unpacker: result kinds, function codes,
// frame offsets and the job record passed from the decoder to the emitter.
// No dependencies.
package mbru_pkg;

    localparam logic [1:0] KIND_BIT   = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_BITS = 2'd1;
    localparam logic [1:0] MODE_REGS = 2'd2;

    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;

    localparam int          POS_W     = 9;
    localparam logic [8:0]  POS_CODE  = 9'd7;
    localparam logic [8:0]  POS_COUNT = 9'd8;
    localparam logic [8:0]  POS_DATA  = 9'd9;
    localparam logic [8:0]  POS_MAX   = 9'd511;

    localparam int          ADDR_W          = 2;
    localparam logic [1:0]  ADDR_BASE_INDEX = 2'd0;

    typedef struct packed {
        logic        emit;
        logic        bits;
        logic [1:0]  kind;
        logic [15:0] dest;
        logic [15:0] word;
        logic        last;
    } job_t;

endpackage

[src/mbru_decode.sv]
// Frame decoder of the modbus response unpacker: tracks the byte offset and
// frame mode, and turns each accepted byte into at most one result job.
// Depends on mbru_pkg.
module mbru_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    input  logic [15:0]       base_index,
    output mbru_pkg::job_t    job
);
    import mbru_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [1:0]       mode_reg, mode_next, mode_eff;
    logic [7:0]       count_reg, count_next, count_eff;
    logic [7:0]       hold_reg, hold_next, hold_eff;
    logic             fin_reg, fin_next, fin_eff;
    logic [POS_W-1:0] data_off;
    logic [POS_W-1:0] data_off_inc;
    logic             past_count;
    logic             final_byte;

    assign pos_eff   = frame_start ? '0 : pos_reg;
    assign mode_eff  = frame_start ? MODE_IDLE : mode_reg;
    assign count_eff = frame_start ? '0 : count_reg;
    assign hold_eff  = frame_start ? '0 : hold_reg;
    assign fin_eff   = frame_start ? 1'b0 : fin_reg;

    assign data_off     = pos_eff - POS_DATA;
    assign data_off_inc = data_off + 9'd1;
    assign past_count   = data_off >= {1'b0, count_eff};
    assign final_byte   = data_off_inc == {1'b0, count_eff};

    always_comb
    begin
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        fin_next   = fin_reg;
        job        = '0;
        if (accept)
        begin
            pos_next   = pos_eff;
            mode_next  = mode_eff;
            count_next = count_eff;
            hold_next  = hold_eff;
            fin_next   = fin_eff;
            if (!fin_eff)
            begin
                if (pos_eff != POS_MAX)
                begin
                    pos_next = pos_eff + 9'd1;
                end
                if (pos_eff == POS_CODE)
                begin
                    if (rx_byte == FC_READ_COILS || rx_byte == FC_READ_DISCRETE)
                    begin
                        mode_next = MODE_BITS;
                    end
                    else if (rx_byte == FC_READ_HOLDING || rx_byte == FC_READ_INPUT)
                    begin
                        mode_next = MODE_REGS;
                    end
                    else
                    begin
                        job.emit = 1'b1;
                        job.kind = KIND_ERROR;
                        job.dest = base_index;
                        job.last = 1'b1;
                        fin_next = 1'b1;
                    end
                end
                else if (pos_eff == POS_COUNT)
                begin
                    count_next = rx_byte;
                    if (rx_byte == 8'd0)
                    begin
                        job.emit = 1'b1;
                        job.kind = KIND_DONE;
                        job.dest = base_index;
                        job.last = 1'b1;
                        fin_next = 1'b1;
                    end
                end
                else if (pos_eff >= POS_DATA)
                begin
                    if (past_count)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        if (final_byte)
                        begin
                            fin_next = 1'b1;
                        end
                        if (mode_eff == MODE_BITS)
                        begin
                            job.emit = 1'b1;
                            job.bits = 1'b1;
                            job.kind = KIND_BIT;
                            job.dest = base_index + 16'({data_off, 3'b000});
                            job.word = {8'd0, rx_byte};
                            job.last = final_byte;
                        end
                        else if (mode_eff == MODE_REGS)
                        begin
                            job.kind = KIND_WORD;
                            job.dest = base_index + 16'(data_off[POS_W-1:1]);
                            if (!data_off[0])
                            begin
                                hold_next = rx_byte;
                                job.emit  = final_byte;
                                job.word  = {rx_byte, 8'd0};
                                job.last  = 1'b1;
                            end
                            else
                            begin
                                job.emit = 1'b1;
                                job.word = {hold_eff, rx_byte};
                                job.last = final_byte;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            hold_reg  <= '0;
            fin_reg   <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

[src/mbru_emit.sv]
// Result emitter of the modbus response unpacker: holds one job and sends its
// results through a registered output stage, one per cycle unless stalled.
// Depends on mbru_pkg and the assertion macro header.
`include "modbus_response_unpacker_macros.svh"

module mbru_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_load,
    input  mbru_pkg::job_t    job_in,
    output logic              job_free,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic [15:0]       dest_index,
    output logic [15:0]       value,
    output logic              last
);
    import mbru_pkg::*;

    job_t        job_reg;
    logic        job_valid_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [15:0] dest_reg;
    logic [15:0] value_reg;
    logic        last_reg;
    logic        out_load;
    logic        job_final;
    logic        job_done;

    assign out_load  = !out_valid_reg || out_ready;
    assign job_final = !job_reg.bits || idx_reg == 3'd7;
    assign job_done  = job_valid_reg && out_load && job_final;
    assign job_free  = !job_valid_reg || job_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (job_valid_reg && out_load)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= job_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
        if (out_load && job_valid_reg)
        begin
            kind_reg <= job_reg.kind;
            last_reg <= job_reg.last && job_final;
            if (job_reg.bits)
            begin
                dest_reg  <= job_reg.dest + 16'(idx_reg);
                value_reg <= {15'd0, job_reg.word[idx_reg]};
            end
            else
            begin
                dest_reg  <= job_reg.dest;
                value_reg <= job_reg.word;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign dest_index  = dest_reg;
    assign value       = value_reg;
    assign last        = last_reg;

    `MBRU_ASSERT_SAME(a_load_only_when_free, clk, rst_n, job_load, job_free, "job loaded while busy")
    `MBRU_ASSERT_SAME(a_index_only_for_bits, clk, rst_n, job_valid_reg && idx_reg != 3'd0, job_reg.bits, "bit index moved on a single-result job")
    `MBRU_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, job_load, job_valid_reg && idx_reg == 3'd0, "loaded job not pending")
    `MBRU_ASSERT_SAME(a_done_is_last, clk, rst_n, out_valid_reg && (kind_reg == KIND_DONE || kind_reg == KIND_ERROR), last_reg && value_reg == 16'd0, "done or error result not final")

endmodule

[src/modbus_response_unpacker.sv]
// Modbus TCP response unpacker, top level: APB register, frame decoder and
// result emitter. Depends on mbru_pkg, mbru_decode and mbru_emit.
//
// The input channel (in_valid, in_ready, rx_byte, frame_start) takes one byte
// of a response frame per transfer; frame_start marks the first MBAP byte.
// The output channel (out_valid, out_ready, result_kind, dest_index, value,
// last) gives one result per transfer. The user writes base_index over the
// APB port at address 0 while the block is idle; the block does not check.
// A byte that produces results passes through the job register and then the
// output register before its first result is valid.
// A coil or discrete input byte produces eight results, one per cycle while
// the receiver is ready; register bytes and bytes without results are taken
// one per cycle while the emitter is free. The next byte is taken in the
// cycle in which the last result of the held byte moves into the output
// register, so the emitter's single job register sets the rate.
// Reset clears the frame state and empties both stages; the block then
// ignores bytes until one arrives with frame_start. When the receiver
// stalls, the output register holds its result and in_ready falls once the
// job register is full.
module modbus_response_unpacker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbru_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  result_kind,
    output logic [15:0]                 dest_index,
    output logic [15:0]                 value,
    output logic                        last
);
    import mbru_pkg::*;

    logic [15:0] base_index_reg;
    logic        accept;
    logic        job_free;
    job_t        job;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BASE_INDEX) ? {16'd0, base_index_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_index_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == ADDR_BASE_INDEX)
        begin
            base_index_reg <= pwdata[15:0];
        end
    end

    assign in_ready = job_free;
    assign accept   = in_valid && job_free;

    mbru_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .base_index  (base_index_reg),
        .job         (job)
    );

    mbru_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_load    (accept && job.emit),
        .job_in      (job),
        .job_free    (job_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .dest_index  (dest_index),
        .value       (value),
        .last        (last)
    );

endmodule

[verif/tb_modbus_response_unpacker.sv]
`timescale 1ns / 1ps
// Self-checking testbench for modbus_response_unpacker: drives Modbus TCP response bytes,
// predicts every unpacked result and checks each output transfer in order.
// Depends on mbru_pkg and the modbus_response_unpacker RTL.
module tb_modbus_response_unpacker;
    import mbru_pkg::*;

    localparam logic [7:0] FC_EXCEPTION = 8'h81;
    localparam int IDLE_SETTLE = 8;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dest;
        logic [15:0] value;
        logic        last;
    } unpacked_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              frame_start;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        result_kind;
    logic [15:0]       dest_index;
    logic [15:0]       value;
    logic              last;

    unpacked_result_t pending_results[$];

    logic [15:0] m_base;
    logic [8:0]  m_pos;
    logic [1:0]  m_mode;
    logic [7:0]  m_count;
    logic [7:0]  m_hold;
    logic        m_finished;

    int  error_count = 0;
    int  results_checked = 0;
    int  bytes_parsed = 0;
    int  frames_sent = 0;
    int  hold_request = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;

    modbus_response_unpacker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .dest_index  (dest_index),
        .value       (value),
        .last        (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void queue_result(input logic [1:0] kind, input logic [15:0] dest,
                                         input logic [15:0] val, input logic fin);
        unpacked_result_t r;
        r.kind = kind;
        r.dest = dest;
        r.value = val;
        r.last = fin;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_unpack(input logic [7:0] b, input logic fs);
        int p;
        int d;
        bit final_byte;
        if (fs)
        begin
            m_pos = '0;
            m_mode = MODE_IDLE;
            m_count = '0;
            m_hold = '0;
            m_finished = 1'b0;
        end
        if (m_finished)
            return;
        bytes_parsed++;
        p = m_pos;
        if (m_pos < POS_MAX)
            m_pos = m_pos + 9'd1;
        if (p < POS_CODE)
            return;
        if (p == POS_CODE)
        begin
            if (b == FC_READ_COILS || b == FC_READ_DISCRETE)
                m_mode = MODE_BITS;
            else if (b == FC_READ_HOLDING || b == FC_READ_INPUT)
                m_mode = MODE_REGS;
            else
            begin
                queue_result(KIND_ERROR, m_base, 16'h0000, 1'b1);
                m_finished = 1'b1;
            end
            return;
        end
        if (p == POS_COUNT)
        begin
            m_count = b;
            if (b == 8'h00)
            begin
                queue_result(KIND_DONE, m_base, 16'h0000, 1'b1);
                m_finished = 1'b1;
            end
            return;
        end
        d = p - POS_DATA;
        if (d >= m_count)
        begin
            m_finished = 1'b1;
            return;
        end
        final_byte = (d + 1 == m_count);
        if (m_mode == MODE_BITS)
        begin
            for (int i = 0; i < 8; i++)
                queue_result(KIND_BIT, 16'(m_base + d * 8 + i), {15'd0, b[i]},
                             final_byte && i == 7);
        end
        else if (m_mode == MODE_REGS)
        begin
            if (d % 2 == 0)
            begin
                m_hold = b;
                if (final_byte)
                    queue_result(KIND_WORD, 16'(m_base + d / 2), {b, 8'h00}, 1'b1);
            end
            else
                queue_result(KIND_WORD, 16'(m_base + d / 2), {m_hold, b}, final_byte);
        end
        if (final_byte)
            m_finished = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 13) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_unpack(b, fs);
    endtask

    task automatic send_frame(input logic [7:0] code, input logic [7:0] count,
                              input int n_data, input int pat);
        logic [7:0] b;
        frames_sent++;
        send_byte(8'($urandom), 1'b1);
        for (int k = 1; k < 7; k++)
            send_byte(8'($urandom), 1'b0);
        send_byte(code, 1'b0);
        send_byte(count, 1'b0);
        for (int k = 0; k < n_data; k++)
        begin
            case (pat)
                1: b = 8'h00;
                2: b = 8'hFF;
                3: b = (k % 2 == 0) ? 8'hA5 : 8'h5A;
                default: b = 8'($urandom);
            endcase
            send_byte(b, 1'b0);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_base(input logic [15:0] want);
        logic [31:0] readback;
        apb_read(ADDR_BASE_INDEX, readback);
        if (readback[15:0] !== want)
        begin
            $error("base_index: expected %h, got %h", want, readback[15:0]);
            error_count++;
        end
    endtask

    task automatic set_base(input logic [15:0] base);
        apb_write(ADDR_BASE_INDEX, {16'($urandom), base});
        m_base = base;
        @(posedge clk);
        check_base(base);
    endtask

    task automatic test_reset_state();
        check_base(16'h0000);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(FC_READ_COILS, 1'b0);
        drain_results();
    endtask

    task automatic test_bit_reads();
        send_frame(FC_READ_COILS, 8'd1, 1, 2);
        send_frame(FC_READ_DISCRETE, 8'd2, 4, 1);
        send_frame(FC_READ_COILS, 8'd3, 3, 3);
        drain_results();
    endtask

    task automatic test_register_reads();
        send_frame(FC_READ_HOLDING, 8'd4, 4, 2);
        send_frame(FC_READ_INPUT, 8'd3, 3, 0);
        send_frame(FC_READ_HOLDING, 8'd1, 2, 3);
        send_frame(FC_READ_INPUT, 8'd2, 2, 1);
        drain_results();
    endtask

    task automatic test_errors_and_empty();
        send_frame(FC_EXCEPTION, 8'd2, 2, 0);
        send_frame(8'h00, 8'd1, 0, 0);
        send_frame(8'hFF, 8'd1, 1, 0);
        send_frame(8'h05, 8'd0, 0, 0);
        send_frame(FC_READ_COILS, 8'd0, 2, 2);
        send_frame(FC_READ_INPUT, 8'd0, 0, 0);
        drain_results();
    endtask

    task automatic test_restart();
        send_byte(8'($urandom), 1'b1);
        for (int k = 0; k < 3; k++)
            send_byte(8'($urandom), 1'b0);
        send_frame(FC_READ_COILS, 8'd4, 2, 0);
        send_frame(FC_READ_HOLDING, 8'd3, 1, 2);
        send_frame(FC_READ_INPUT, 8'd2, 2, 0);
        drain_results();
    endtask

    task automatic test_index_wrap();
        set_base(16'hFFFF);
        send_frame(FC_READ_COILS, 8'd1, 1, 0);
        send_frame(FC_READ_HOLDING, 8'd4, 4, 0);
        send_frame(FC_EXCEPTION, 8'd0, 0, 0);
        drain_results();
        set_base(16'hFFFA);
        send_frame(FC_READ_DISCRETE, 8'd2, 2, 3);
        drain_results();
    endtask

    task automatic test_backpressure();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        hold_request = LONG_HOLD;
        send_frame(FC_READ_DISCRETE, 8'd12, 12, 0);
        send_frame(FC_READ_HOLDING, 8'd8, 8, 0);
        drain_results();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items);
        int start;
        int sel;
        int n_data;
        logic [7:0] code;
        logic [7:0] count;
        start = bytes_parsed;
        while (bytes_parsed - start < n_items)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), $urandom_range(0, 5) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 20)
                code = FC_READ_COILS;
            else if (sel < 38)
                code = FC_READ_DISCRETE;
            else if (sel < 58)
                code = FC_READ_HOLDING;
            else if (sel < 78)
                code = FC_READ_INPUT;
            else if (sel < 86)
                code = FC_EXCEPTION;
            else
                code = 8'($urandom);
            if ($urandom_range(0, 19) == 0)
                count = 8'($urandom_range(128, 255));
            else
                count = 8'($urandom_range(0, 9));
            sel = $urandom_range(0, 99);
            if (count > 16)
                n_data = $urandom_range(0, 24);
            else if (sel < 70)
                n_data = count;
            else if (sel < 85)
                n_data = count + $urandom_range(1, 3);
            else
                n_data = $urandom_range(0, count);
            send_frame(code, count, n_data, 0);
        end
        drain_results();
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        frame_start = 1'b0;
        m_base = '0;
        m_pos = '0;
        m_mode = MODE_IDLE;
        m_count = '0;
        m_hold = '0;
        m_finished = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_bit_reads();
        test_register_reads();
        test_errors_and_empty();
        test_restart();
        test_index_wrap();
        test_backpressure();
        set_base(16'($urandom));
        test_random_traffic(20);
        set_base(16'hFFF8);
        test_random_traffic(20);
        set_base(16'h0000);
        test_random_traffic(20);
        set_base(16'($urandom));
        test_random_traffic(20);
        drain_results();

        $display("Sent %0d frames (%0d bytes parsed): coil, input and register reads, errors,",
                 frames_sent, bytes_parsed);
        $display("empty responses, restarts, index wrap and stalls; %0d results checked.",
                 results_checked);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin : take_result
            int stall;
            unpacked_result_t want;
            stall = receiver_gaps ? $urandom_range(0, 13) : 0;
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            repeat (stall)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d dest %h value %h last %0d",
                       result_kind, dest_index, value, last);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                    error_count++;
                end
                if (dest_index !== want.dest)
                begin
                    $error("dest_index: expected %h, got %h", want.dest, dest_index);
                    error_count++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, value);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles, %0d results still expected",
               STALL_LIMIT, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
